/* src/rfid_pkg.sv */
// Shared types and constants for the RFID ASCII frame parser.
`timescale 1ns / 1ps

package rfid_pkg;

    localparam int FRAME_LEN = 14;
    localparam int IDX_W     = 4;
    localparam int ID_W      = 40;
    localparam int BYTE_W    = 8;
    localparam int STAT_W    = 3;

    localparam logic [IDX_W-1:0] FRAME_LEN_IDX  = IDX_W'(FRAME_LEN);
    localparam logic [IDX_W-1:0] FIRST_DIGIT    = IDX_W'(1);
    localparam logic [IDX_W-1:0] LAST_ID_DIGIT  = IDX_W'(10);
    localparam logic [IDX_W-1:0] LAST_DIGIT     = IDX_W'(12);

    localparam logic [BYTE_W-1:0] CHAR_0 = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_9 = 8'd57;
    localparam logic [BYTE_W-1:0] CHAR_A = 8'd65;
    localparam logic [BYTE_W-1:0] CHAR_F = 8'd70;

    localparam logic [BYTE_W-1:0] START_RESET = 8'd2;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'd3;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_REARM = 1'b1;

    localparam logic [STAT_W-1:0] STAT_NONE    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LEN     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_SUM     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DIGIT   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
        logic is_sum;
    } t_acc_ctl;

endpackage

/* src/rfid_frame_buf.sv */
// Frame byte store with one write port and one registered read port.
`timescale 1ns / 1ps

module rfid_frame_buf
    import rfid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [FRAME_LEN];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rfid_hex_acc.sv */
// Shared hex digit decoder with id and checksum accumulators.
`timescale 1ns / 1ps

module rfid_hex_acc
    import rfid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_ctl          i_ctl,
    input  logic [BYTE_W-1:0] i_char,
    output logic [ID_W-1:0]   o_id,
    output logic [BYTE_W-1:0] o_got,
    output logic              o_bad
);

    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] ch);
        logic [4:0] res;
        res = 5'b10000;
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
            res = {1'b0, 4'(ch - CHAR_0)};
        end else if (ch >= CHAR_A && ch <= CHAR_F) begin
            res = {1'b0, 4'(ch - CHAR_A + 8'd10)};
        end
        return res;
    endfunction

    logic [ID_W-1:0]   r_id,  n_id;
    logic [BYTE_W-1:0] r_got, n_got;
    logic              r_bad, n_bad;
    logic [4:0]        dec;

    always_comb begin
        dec   = hex_decode(i_char);
        n_id  = r_id;
        n_got = r_got;
        n_bad = r_bad;
        if (i_ctl.clear) begin
            n_id  = '0;
            n_got = '0;
            n_bad = 1'b0;
        end else if (i_ctl.step) begin
            n_bad = r_bad | dec[4];
            if (i_ctl.is_sum) begin
                n_got = {r_got[3:0], dec[3:0]};
            end else begin
                n_id = {r_id[ID_W-5:0], dec[3:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad <= 1'b0;
        end else begin
            r_bad <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_got <= n_got;
    end

    assign o_id  = r_id;
    assign o_got = r_got;
    assign o_bad = r_bad;

endmodule

/* src/rfid_ascii_frame_parser_core.sv */
// Top level of the RFID ASCII hex frame parser: sequencer, index and card id state.
`timescale 1ns / 1ps

// Takes reader bytes one word at a time and returns exactly one result word per input word.
// A received byte or a rearm passes through the emit state into the output register.
// An end byte that closes a full 14-byte frame first goes through a walk over the twelve stored
// digits, with one frame-buffer read and one pass through the shared hex decoder per cycle,
// then through the flush, check and emit states. The emit state waits while an earlier result
// is still held in the output register. The input is not ready while a word is in work. One
// finished result can wait in the output register while the next word is taken and worked on.
// Start and end byte values (reset 2 and 3) must be written by the user through the
// configuration port only while the block is idle; the block itself does not enforce this.
// Each result carries as card_id the last card id whose frame had valid digits and checksum.

module rfid_ascii_frame_parser_core
    import rfid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_card_id
);

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_start, r_end;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_halted, n_halted;
    logic [ID_W-1:0]   r_last_id, n_last_id;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_sum, n_rd_sum;
    logic [STAT_W-1:0] r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]   r_out_card, n_out_card;

    logic              in_acc;
    logic              is_start, closing;
    logic [IDX_W-1:0]  idx0, idx_w, idx_next;
    logic              buf_we;
    logic [BYTE_W-1:0] rd_data;
    t_acc_ctl          acc_ctl;
    logic [ID_W-1:0]   acc_id;
    logic [BYTE_W-1:0] acc_got;
    logic              acc_bad;
    logic [BYTE_W-1:0] id_xor;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign is_start = (i_data_byte == r_start);
    assign closing  = !is_start && (i_data_byte == r_end);
    assign idx0     = is_start ? '0 : r_idx;
    assign idx_w    = (idx0 >= FRAME_LEN_IDX) ? '0 : idx0;
    assign idx_next = idx_w + IDX_W'(1);

    assign id_xor = acc_id[39:32] ^ acc_id[31:24] ^ acc_id[23:16] ^ acc_id[15:8] ^ acc_id[7:0];

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_halted     = r_halted;
        n_last_id    = r_last_id;
        n_pos        = r_pos;
        n_rd_vld     = 1'b0;
        n_rd_sum     = 1'b0;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_card   = r_out_card;
        buf_we       = 1'b0;
        acc_ctl      = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EMIT;
                    n_pend  = STAT_NONE;
                    if (i_action == ACT_REARM) begin
                        n_halted = 1'b0;
                    end else if (r_halted) begin
                        n_pend = STAT_IGNORED;
                    end else begin
                        buf_we = 1'b1;
                        n_idx  = idx_next;
                        if (closing) begin
                            n_halted = 1'b1;
                            if (idx_next == FRAME_LEN_IDX) begin
                                acc_ctl.clear = 1'b1;
                                n_pos         = FIRST_DIGIT;
                                n_state       = S_WALK;
                            end else begin
                                n_pend = STAT_LEN;
                            end
                        end
                    end
                end
            end
            S_WALK: begin
                acc_ctl.step   = r_rd_vld;
                acc_ctl.is_sum = r_rd_sum;
                n_rd_vld = 1'b1;
                n_rd_sum = (r_pos > LAST_ID_DIGIT);
                n_pos    = r_pos + IDX_W'(1);
                if (r_pos == LAST_DIGIT) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                acc_ctl.step   = r_rd_vld;
                acc_ctl.is_sum = r_rd_sum;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (acc_bad) begin
                    n_pend = STAT_DIGIT;
                end else if (acc_got != id_xor) begin
                    n_pend = STAT_SUM;
                end else begin
                    n_pend    = STAT_OK;
                    n_last_id = acc_id;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    n_out_card   = r_last_id;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= START_RESET;
            r_end       <= END_RESET;
            r_idx       <= '0;
            r_halted    <= 1'b0;
            r_last_id   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_halted    <= n_halted;
            r_last_id   <= n_last_id;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START) begin
                    r_start <= i_cfg_data;
                end else begin
                    r_end <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_rd_sum     <= n_rd_sum;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_card   <= n_out_card;
    end

    rfid_frame_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (idx_w),
        .i_wdata (i_data_byte),
        .i_raddr (r_pos),
        .o_rdata (rd_data)
    );

    rfid_hex_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_char  (rd_data),
        .o_id    (acc_id),
        .o_got   (acc_got),
        .o_bad   (acc_bad)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_card_id   = r_out_card;

endmodule

/* src/rfid_checker.sv */
// Port-level checks for the RFID ASCII frame parser, bound to the top level.
`timescale 1ns / 1ps

module rfid_checker
    import rfid_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] o_status,
    input logic [ID_W-1:0]   o_card_id
);

    logic [ID_W-1:0] r_prev_card;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_card <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_prev_card <= o_card_id;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_card_id))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again before result was formed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= STAT_IGNORED)
        else $error("status code out of range");

    a_card_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_status != STAT_OK |-> o_card_id == r_prev_card)
        else $error("card id changed without an accepted frame");

endmodule

bind rfid_ascii_frame_parser_core rfid_checker u_rfid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_card_id   (o_card_id)
);
